// File: src/mngq_pkg.sv
// ----------------------------------------------------------------------------
// mngq_pkg
// Shared types and constants of the MIDI note grid quantiser.
// ----------------------------------------------------------------------------
package mngq_pkg;

    localparam int NOTE_SLOTS  = 16 * 128;
    localparam int SLOT_W      = $clog2(NOTE_SLOTS);
    localparam int QUEUE_DEPTH = 4;
    localparam int EPOCH_W     = 8;

    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;

    localparam logic [1:0] REG_LOOP_LENGTH  = 2'd0;
    localparam logic [1:0] REG_GRID_STEP    = 2'd1;
    localparam logic [1:0] REG_PHASE_OFFSET = 2'd2;

    // one classified event waiting for the back end
    typedef struct packed {
        logic              start;
        logic              is_on;
        logic              is_off;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        status;
        logic [6:0]        note;
        logic [6:0]        vel;
        logic [31:0]       t;
    } mngq_item_t;

endpackage

// File: src/midi_note_grid_quantiser_unit.sv
// ----------------------------------------------------------------------------
// midi_note_grid_quantiser_unit
// Snaps note-on times to a phase-shifted grid and moves the matching
// note-offs by the same amount, one MIDI event per beat.
// ----------------------------------------------------------------------------
// Every input beat gives exactly one output beat, in order. A note-on inside
// the loop is snapped by the 33-step remainder unit doing the grid division;
// the first such note after a write to loop_length or phase_offset first has
// its wrapped phase recomputed on the same unit. After reset, and on every
// 256th start_of_batch, the per-note queue table is swept over all 2048 slots
// while s_tready stays low. A two-entry input queue and the output register
// let both sides stall independently.
module midi_note_grid_quantiser_unit #(
    parameter int QUEUE_DEPTH = mngq_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // tdata: status_byte[7:0], note_number[14:8], velocity[21:15],
    //        sample_offset[53:22], zero fill
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic        s_tuser,   // start_of_batch
    // tdata: out_status[7:0], out_note[14:8], out_velocity[21:15],
    //        out_sample_offset[53:22], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,
    output logic        m_tuser,   // queue_overflow
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] loop_length_reg, loop_length_next;
    logic [31:0] grid_step_reg, grid_step_next;
    logic [31:0] phase_offset_reg, phase_offset_next;
    logic        cfg_wr;
    logic        phase_stale;
    logic        hold;
    logic        pop;
    logic        item_valid;
    mngq_pkg::mngq_item_t item;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        loop_length_next  = loop_length_reg;
        grid_step_next    = grid_step_reg;
        phase_offset_next = phase_offset_reg;
        phase_stale       = 1'b0;
        if (cfg_wr) begin
            unique case (paddr[3:2])
                mngq_pkg::REG_LOOP_LENGTH: begin
                    loop_length_next = pwdata;
                    phase_stale      = 1'b1;
                end
                mngq_pkg::REG_GRID_STEP: begin
                    grid_step_next = pwdata;
                end
                mngq_pkg::REG_PHASE_OFFSET: begin
                    phase_offset_next = pwdata;
                    phase_stale       = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            mngq_pkg::REG_LOOP_LENGTH:  prdata = loop_length_reg;
            mngq_pkg::REG_GRID_STEP:    prdata = grid_step_reg;
            mngq_pkg::REG_PHASE_OFFSET: prdata = phase_offset_reg;
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loop_length_reg  <= '0;
            grid_step_reg    <= '0;
            phase_offset_reg <= '0;
        end else begin
            loop_length_reg  <= loop_length_next;
            grid_step_reg    <= grid_step_next;
            phase_offset_reg <= phase_offset_next;
        end
    end

    mngq_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .hold       (hold),
        .pop        (pop),
        .item_valid (item_valid),
        .item       (item)
    );

    mngq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .loop_length  (loop_length_reg),
        .grid_step    (grid_step_reg),
        .phase_offset (phase_offset_reg),
        .phase_stale  (phase_stale),
        .item_valid   (item_valid),
        .item         (item),
        .pop          (pop),
        .clearing     (hold),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

endmodule

// File: src/mngq_ram.sv
// ----------------------------------------------------------------------------
// mngq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mngq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/mngq_div.sv
// ----------------------------------------------------------------------------
// mngq_div
// Restoring bit-serial remainder unit, 33-bit dividend by 32-bit divisor.
// ----------------------------------------------------------------------------
module mngq_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [32:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] rem
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [32:0] q_reg, q_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [32:0] trial;

    assign trial = {r_reg, q_reg[32]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end else if (busy_reg) begin
            q_next = {q_reg[31:0], 1'b0};
            if (trial >= {1'b0, d_reg}) begin
                r_next = 32'(trial - {1'b0, d_reg});
            end else begin
                r_next = trial[31:0];
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd32) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign rem  = r_reg;

endmodule

// File: src/mngq_front.sv
// ----------------------------------------------------------------------------
// mngq_front
// Accepts input beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module mngq_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [55:0]            s_tdata,
    input  logic                   s_tuser,
    input  logic                   hold,
    input  logic                   pop,
    output logic                   item_valid,
    output mngq_pkg::mngq_item_t   item
);

    mngq_pkg::mngq_item_t fifo_reg [2];
    mngq_pkg::mngq_item_t in_item;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic [3:0] kind;

    assign kind = s_tdata[7:4];

    always_comb begin
        in_item.start  = s_tuser;
        in_item.status = s_tdata[7:0];
        in_item.note   = s_tdata[14:8];
        in_item.vel    = s_tdata[21:15];
        in_item.t      = s_tdata[53:22];
        in_item.slot   = {s_tdata[3:0], s_tdata[14:8]};
        in_item.is_on  = (kind == mngq_pkg::KIND_NOTE_ON) && (s_tdata[21:15] != 7'd0);
        in_item.is_off = (kind == mngq_pkg::KIND_NOTE_OFF) ||
                         ((kind == mngq_pkg::KIND_NOTE_ON) && (s_tdata[21:15] == 7'd0));
    end

    assign s_tready   = (cnt_reg != 2'd2) && !hold;
    assign push       = s_tvalid && s_tready;
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = fifo_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (push) begin
            fifo_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: src/mngq_back.sv
// ----------------------------------------------------------------------------
// mngq_back
// Sequencer that quantises note-ons, replays queued shifts on note-offs and
// drives the output register.
// ----------------------------------------------------------------------------
module mngq_back #(
    parameter int QUEUE_DEPTH = mngq_pkg::QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [31:0]          loop_length,
    input  logic [31:0]          grid_step,
    input  logic [31:0]          phase_offset,
    input  logic                 phase_stale,
    input  logic                 item_valid,
    input  mngq_pkg::mngq_item_t item,
    output logic                 pop,
    output logic                 clearing,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [55:0]          m_tdata,
    output logic                 m_tuser
);

    localparam int HW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int EW    = mngq_pkg::EPOCH_W;
    localparam int MW    = EW + HW + CW;
    localparam int SW    = mngq_pkg::SLOT_W;
    localparam int SLOTS = mngq_pkg::NOTE_SLOTS;
    localparam int AW    = $clog2(SLOTS * QUEUE_DEPTH);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_LOOKUP = 4'd2;
    localparam logic [3:0] ST_META   = 4'd3;
    localparam logic [3:0] ST_PDIV   = 4'd4;
    localparam logic [3:0] ST_PWAIT  = 4'd5;
    localparam logic [3:0] ST_REL    = 4'd6;
    localparam logic [3:0] ST_RDIV   = 4'd7;
    localparam logic [3:0] ST_RWAIT  = 4'd8;
    localparam logic [3:0] ST_ADDPW  = 4'd9;
    localparam logic [3:0] ST_WRAP1  = 4'd10;
    localparam logic [3:0] ST_WRAP2  = 4'd11;
    localparam logic [3:0] ST_QPUSH  = 4'd12;
    localparam logic [3:0] ST_SADDR  = 4'd13;
    localparam logic [3:0] ST_SREAD  = 4'd14;
    localparam logic [3:0] ST_OUT    = 4'd15;

    logic [3:0]           state_reg, state_next;
    mngq_pkg::mngq_item_t cur_reg, cur_next;
    logic [EW-1:0]        epoch_reg, epoch_next;
    logic [SW-1:0]        clr_cnt_reg, clr_cnt_next;
    logic                 pend_reg, pend_next;
    logic [HW-1:0]        head_reg, head_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [31:0]          pw_reg, pw_next;
    logic                 stale_reg, stale_next;
    logic [33:0]          acc_reg, acc_next;
    logic [31:0]          res_reg, res_next;
    logic                 ovf_reg, ovf_next;
    logic                 m_valid_reg, m_valid_next;
    logic [55:0]          m_data_reg, m_data_next;
    logic                 m_user_reg, m_user_next;

    logic          meta_we;
    logic [SW-1:0] meta_waddr;
    logic [MW-1:0] meta_wdata, meta_rdata;
    logic          sh_we;
    logic [AW-1:0] sh_waddr, sh_raddr, slot_base;
    logic [32:0]   sh_wdata, sh_rdata;

    logic        div_start, div_done;
    logic [32:0] div_dividend;
    logic [31:0] div_divisor, div_rem;

    logic          phase_neg;
    logic [31:0]   phase_mag;
    logic [32:0]   rel_sum, rel_val;
    logic [HW:0]   pos_sum;
    logic [HW-1:0] pos, head_inc;
    logic [33:0]   off_sum;
    logic          meta_live;
    logic          out_free;

    mngq_ram #(.WIDTH(MW), .DEPTH(SLOTS)) u_meta_ram (
        .aclk  (aclk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (cur_reg.slot),
        .rdata (meta_rdata)
    );

    mngq_ram #(.WIDTH(33), .DEPTH(SLOTS * QUEUE_DEPTH)) u_shift_ram (
        .aclk  (aclk),
        .we    (sh_we),
        .waddr (sh_waddr),
        .wdata (sh_wdata),
        .raddr (sh_raddr),
        .rdata (sh_rdata)
    );

    mngq_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .rem      (div_rem)
    );

    assign phase_neg = phase_offset[31];
    assign phase_mag = phase_neg ? (32'd0 - phase_offset) : phase_offset;
    assign slot_base = AW'(cur_reg.slot) * AW'(QUEUE_DEPTH);
    assign sh_raddr  = slot_base + AW'(head_reg);
    assign meta_live = (meta_rdata[MW-1 -: EW] == epoch_reg);
    assign out_free  = !m_valid_reg || m_tready;

    // loop-relative time, t + len - phase folded once into the loop
    assign rel_sum = {1'b0, cur_reg.t} + {1'b0, loop_length} - {1'b0, pw_reg};
    assign rel_val = (rel_sum >= {1'b0, loop_length}) ? (rel_sum - {1'b0, loop_length})
                                                       : rel_sum;

    assign pos_sum  = (HW+1)'(head_reg) + (HW+1)'(cnt_reg);
    assign pos      = (pos_sum >= (HW+1)'(QUEUE_DEPTH)) ?
                      HW'(pos_sum - (HW+1)'(QUEUE_DEPTH)) : HW'(pos_sum);
    assign head_inc = ((HW+1)'(head_reg) + (HW+1)'(1) == (HW+1)'(QUEUE_DEPTH)) ?
                      '0 : HW'((HW+1)'(head_reg) + (HW+1)'(1));
    assign off_sum  = {2'b00, cur_reg.t} + {sh_rdata[32], sh_rdata};

    assign clearing = (state_reg == ST_CLEAR);

    always_comb begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        epoch_next   = epoch_reg;
        clr_cnt_next = clr_cnt_reg;
        pend_next    = pend_reg;
        head_next    = head_reg;
        cnt_next     = cnt_reg;
        pw_next      = pw_reg;
        stale_next   = stale_reg || phase_stale;
        acc_next     = acc_reg;
        res_next     = res_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        pop          = 1'b0;
        meta_we      = 1'b0;
        meta_waddr   = cur_reg.slot;
        meta_wdata   = '0;
        sh_we        = 1'b0;
        sh_waddr     = slot_base + AW'(pos);
        sh_wdata     = 33'({1'b0, res_reg} - {1'b0, cur_reg.t});
        div_start    = 1'b0;
        div_dividend = {1'b0, phase_mag};
        div_divisor  = loop_length;

        unique case (state_reg)
            ST_CLEAR: begin
                meta_we      = 1'b1;
                meta_waddr   = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + SW'(1);
                if (clr_cnt_reg == SW'(SLOTS - 1)) begin
                    pend_next  = 1'b0;
                    state_next = pend_reg ? ST_LOOKUP : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (item_valid) begin
                    pop        = 1'b1;
                    cur_next   = item;
                    state_next = ST_LOOKUP;
                    if (item.start) begin
                        // epoch wrap needs a real sweep so old marks cannot match
                        if (epoch_reg == '1) begin
                            epoch_next   = '0;
                            clr_cnt_next = '0;
                            pend_next    = 1'b1;
                            state_next   = ST_CLEAR;
                        end else begin
                            epoch_next = epoch_reg + EW'(1);
                        end
                    end
                end
            end
            ST_LOOKUP: begin
                state_next = ST_META;
            end
            ST_META: begin
                head_next  = meta_live ? meta_rdata[CW +: HW] : '0;
                cnt_next   = meta_live ? meta_rdata[CW-1:0] : '0;
                res_next   = cur_reg.t;
                ovf_next   = 1'b0;
                state_next = ST_OUT;
                if (loop_length != 32'd0 && grid_step != 32'd0) begin
                    if (cur_reg.is_on) begin
                        if (cur_reg.t < loop_length) begin
                            state_next = stale_reg ? ST_PDIV : ST_REL;
                        end
                    end else if (cur_reg.is_off) begin
                        if (meta_live && meta_rdata[CW-1:0] != '0) begin
                            state_next = ST_SADDR;
                        end
                    end
                end
            end
            ST_PDIV: begin
                div_start  = 1'b1;
                state_next = ST_PWAIT;
            end
            ST_PWAIT: begin
                if (div_done) begin
                    pw_next    = (phase_neg && div_rem != 32'd0) ? (loop_length - div_rem)
                                                                 : div_rem;
                    stale_next = phase_stale;
                    state_next = ST_REL;
                end
            end
            ST_REL: begin
                acc_next   = {1'b0, rel_val};
                state_next = ST_RDIV;
            end
            ST_RDIV: begin
                div_start    = 1'b1;
                div_dividend = 33'(acc_reg + {3'b000, grid_step[31:1]});
                div_divisor  = grid_step;
                acc_next     = acc_reg + {3'b000, grid_step[31:1]};
                state_next   = ST_RWAIT;
            end
            ST_RWAIT: begin
                if (div_done) begin
                    acc_next   = acc_reg - {2'b00, div_rem};
                    state_next = ST_ADDPW;
                end
            end
            ST_ADDPW: begin
                acc_next   = acc_reg + {2'b00, pw_reg};
                state_next = ST_WRAP1;
            end
            ST_WRAP1: begin
                if (acc_reg >= {2'b00, loop_length}) begin
                    acc_next = acc_reg - {2'b00, loop_length};
                end
                state_next = ST_WRAP2;
            end
            ST_WRAP2: begin
                if (acc_reg >= {2'b00, loop_length}) begin
                    res_next = 32'(acc_reg - {2'b00, loop_length});
                end else begin
                    res_next = acc_reg[31:0];
                end
                state_next = ST_QPUSH;
            end
            ST_QPUSH: begin
                if (cnt_reg >= CW'(QUEUE_DEPTH)) begin
                    ovf_next = 1'b1;
                end else begin
                    sh_we      = 1'b1;
                    meta_we    = 1'b1;
                    meta_wdata = {epoch_reg, head_reg, CW'(cnt_reg + CW'(1))};
                end
                state_next = ST_OUT;
            end
            ST_SADDR: begin
                state_next = ST_SREAD;
            end
            ST_SREAD: begin
                meta_we    = 1'b1;
                meta_wdata = {epoch_reg, head_inc, CW'(cnt_reg - CW'(1))};
                if (off_sum[33]) begin
                    res_next = '0;
                end else if (off_sum >= {2'b00, loop_length}) begin
                    res_next = loop_length - 32'd1;
                end else begin
                    res_next = off_sum[31:0];
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {2'b00, res_reg, cur_reg.vel, cur_reg.note, cur_reg.status};
                    m_user_next  = ovf_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            epoch_reg   <= '0;
            clr_cnt_reg <= '0;
            pend_reg    <= 1'b0;
            stale_reg   <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            epoch_reg   <= epoch_next;
            clr_cnt_reg <= clr_cnt_next;
            pend_reg    <= pend_next;
            stale_reg   <= stale_next;
            m_valid_reg <= m_valid_next;
        end
        cur_reg    <= cur_next;
        head_reg   <= head_next;
        cnt_reg    <= cnt_next;
        pw_reg     <= pw_next;
        acc_reg    <= acc_next;
        res_reg    <= res_next;
        ovf_reg    <= ovf_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
